[sv/vertex_dedup_indexer_unit_macros.svh]
// Assertion macros for the vertex dedup indexer
`ifndef VERTEX_DEDUP_INDEXER_UNIT_MACROS_SVH
`define VERTEX_DEDUP_INDEXER_UNIT_MACROS_SVH
// implication checked every cycle outside reset
`define VDI_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
// next-cycle implication checked outside reset
`define VDI_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`endif

[sv/vdi_pkg.sv]
// ----------------------------------------------------------------------------
// vdi_pkg
// Types and command codes shared by the vertex dedup indexer.
// ----------------------------------------------------------------------------
package vdi_pkg;

  localparam logic [1:0] CMD_ADD_POS  = 2'd0;
  localparam logic [1:0] CMD_ADD_TEX  = 2'd1;
  localparam logic [1:0] CMD_ADD_NRM  = 2'd2;
  localparam logic [1:0] CMD_CORNER   = 2'd3;
  localparam int unsigned VWORDS      = 8;

  typedef struct packed {
    logic [1:0]         command;
    logic [31:0]        word_a;
    logic [31:0]        word_b;
    logic [31:0]        word_c;
    logic signed [11:0] pos_index;
    logic signed [11:0] tex_index;
    logic signed [11:0] norm_index;
  } vdi_in_t;

  typedef struct packed {
    logic [9:0]  slot_index;
    logic        is_new;
    logic        store_full;
    logic [31:0] pos_x;
    logic [31:0] pos_y;
    logic [31:0] pos_z;
    logic [31:0] tex_u;
    logic [31:0] tex_v;
    logic [31:0] nrm_x;
    logic [31:0] nrm_y;
    logic [31:0] nrm_z;
  } vdi_out_t;

  typedef logic [VWORDS*32-1:0] vdi_vtx_t;

endpackage

[sv/vdi_attr_mem.sv]
// ----------------------------------------------------------------------------
// vdi_attr_mem
// Attribute store: one row of up to three words per slot, one port.
// ----------------------------------------------------------------------------
module vdi_attr_mem import vdi_pkg::*; #(
  parameter int DEPTH = 1024,
  parameter int AW    = 10
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] addr,
  input  logic [95:0]   wdata,
  output logic [95:0]   rdata
);
  logic [95:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end
endmodule

[sv/vdi_vtx_mem.sv]
// ----------------------------------------------------------------------------
// vdi_vtx_mem
// Unique vertex store: one eight-word row per entry, one port.
// ----------------------------------------------------------------------------
module vdi_vtx_mem import vdi_pkg::*; #(
  parameter int DEPTH = 1024,
  parameter int AW    = 10
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] addr,
  input  vdi_vtx_t      wdata,
  output vdi_vtx_t      rdata
);
  vdi_vtx_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end
endmodule

[sv/vertex_dedup_indexer_unit.sv]
// ----------------------------------------------------------------------------
// vertex_dedup_indexer_unit
// Attribute stores plus a sequencer that scans unique vertices for a match and appends a miss.
// ----------------------------------------------------------------------------
// Usage: drive in_req with start high while busy is low; the request is taken
// at that edge. Each request gives exactly one result: out_valid pulses for one
// cycle with out_rsp. The receiver cannot stall, so results are never held.
// Add requests (position, texcoord, normal) go from acceptance to S_DONE,
// which registers the result strobe.
// A face corner latches its three attributes in S_READ, waits in S_LOAD for entry
// zero, then the shared row compare walks the unique vertex store one entry
// per cycle through its single read port until a match or the end of the
// stored entries; on a miss the append write takes its own S_SCAN step after
// the last compare, or store_full is flagged when the store is full.
// busy stays high from acceptance through the result cycle, so the next
// request is taken in the cycle after the result at the earliest.
// Reset (synchronous, rst_n low) clears all counts; store contents are not
// cleared and only entries below a count are ever used.
// slot_index carries the low 10 bits of the slot or unique index.
// ----------------------------------------------------------------------------
module vertex_dedup_indexer_unit import vdi_pkg::*; #(
  parameter int ATTR_DEPTH   = 1024,
  parameter int UNIQUE_DEPTH = 1024
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     start,
  output logic     busy,
  input  vdi_in_t  in_req,
  output logic     out_valid,
  output vdi_out_t out_rsp
);
`include "vertex_dedup_indexer_unit_macros.svh"

  localparam int AAW = (ATTR_DEPTH > 1) ? $clog2(ATTR_DEPTH) : 1;
  localparam int UAW = (UNIQUE_DEPTH > 1) ? $clog2(UNIQUE_DEPTH) : 1;
  localparam int ACW = $clog2(ATTR_DEPTH + 1);
  localparam int UCW = $clog2(UNIQUE_DEPTH + 1);

  typedef enum logic [2:0] {
    S_IDLE, S_READ, S_LOAD, S_SCAN, S_DONE
  } state_t;

  state_t          state_r;
  logic [ACW-1:0]  pcnt_r, tcnt_r, ncnt_r;
  logic [UCW-1:0]  ucnt_r;
  logic [UCW-1:0]  scan_r;
  vdi_vtx_t        vtx_r;
  logic            pok_r, tok_r, nok_r;
  vdi_out_t        rsp_r;
  logic            valid_r;

  logic            acc;
  logic            pwe, twe, nwe, uwe;
  logic [AAW-1:0]  paddr, taddr, naddr;
  logic [UAW-1:0]  uaddr;
  logic [95:0]     prd, trd, nrd, awdata;
  vdi_vtx_t        urd;
  logic            hit;

  assign acc = start && !busy;
  assign awdata = {in_req.word_a, in_req.word_b, in_req.word_c};
  assign pwe = acc && (in_req.command == CMD_ADD_POS) && (pcnt_r < ACW'(ATTR_DEPTH));
  assign twe = acc && (in_req.command == CMD_ADD_TEX) && (tcnt_r < ACW'(ATTR_DEPTH));
  assign nwe = acc && (in_req.command == CMD_ADD_NRM) && (ncnt_r < ACW'(ATTR_DEPTH));
  assign paddr = pwe ? pcnt_r[AAW-1:0] : AAW'(in_req.pos_index[10:0]);
  assign taddr = twe ? tcnt_r[AAW-1:0] : AAW'(in_req.tex_index[10:0]);
  assign naddr = nwe ? ncnt_r[AAW-1:0] : AAW'(in_req.norm_index[10:0]);

  vdi_attr_mem #(.DEPTH(ATTR_DEPTH), .AW(AAW)) u_pos (
    .clk(clk), .we(pwe), .addr(paddr), .wdata(awdata), .rdata(prd));
  vdi_attr_mem #(.DEPTH(ATTR_DEPTH), .AW(AAW)) u_tex (
    .clk(clk), .we(twe), .addr(taddr), .wdata(awdata), .rdata(trd));
  vdi_attr_mem #(.DEPTH(ATTR_DEPTH), .AW(AAW)) u_nrm (
    .clk(clk), .we(nwe), .addr(naddr), .wdata(awdata), .rdata(nrd));

  // read address runs one ahead of the compare
  logic [UCW-1:0] scan_nxt;
  assign scan_nxt = (state_r == S_SCAN) ? scan_r + UCW'(1) : '0;
  assign uwe   = (state_r == S_SCAN) && !hit && (scan_r >= ucnt_r)
                 && (ucnt_r < UCW'(UNIQUE_DEPTH));
  assign uaddr = uwe ? ucnt_r[UAW-1:0] : scan_nxt[UAW-1:0];

  vdi_vtx_mem #(.DEPTH(UNIQUE_DEPTH), .AW(UAW)) u_vtx (
    .clk(clk), .we(uwe), .addr(uaddr), .wdata(vtx_r), .rdata(urd));

  assign hit = (state_r == S_SCAN) && (scan_r < ucnt_r) && (urd == vtx_r);

  function automatic logic slot_ok(input logic signed [11:0] idx,
                                   input logic [ACW-1:0] cnt);
    logic [31:0] ext;
    logic [31:0] c;
    ext = 32'(idx[10:0]);
    c   = 32'(cnt);
    return !idx[11] && (ext < c);
  endfunction

  function automatic vdi_out_t add_rsp(input logic ok, input logic [9:0] slot);
    vdi_out_t o;
    o = '0;
    o.store_full = !ok;
    o.slot_index = ok ? slot : '0;
    return o;
  endfunction

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      pcnt_r  <= '0;
      tcnt_r  <= '0;
      ncnt_r  <= '0;
      ucnt_r  <= '0;
      valid_r <= 1'b0;
      scan_r  <= '0;
    end else begin
      valid_r <= 1'b0;
      unique case (state_r)
        S_IDLE: begin
          if (acc) begin
            if (pwe) pcnt_r <= pcnt_r + ACW'(1);
            if (twe) tcnt_r <= tcnt_r + ACW'(1);
            if (nwe) ncnt_r <= ncnt_r + ACW'(1);
            pok_r   <= slot_ok(in_req.pos_index, pcnt_r);
            tok_r   <= slot_ok(in_req.tex_index, tcnt_r);
            nok_r   <= slot_ok(in_req.norm_index, ncnt_r);
            unique case (in_req.command)
              CMD_ADD_POS: begin
                rsp_r   <= add_rsp(pwe, 10'(pcnt_r));
                state_r <= S_DONE;
              end
              CMD_ADD_TEX: begin
                rsp_r   <= add_rsp(twe, 10'(tcnt_r));
                state_r <= S_DONE;
              end
              CMD_ADD_NRM: begin
                rsp_r   <= add_rsp(nwe, 10'(ncnt_r));
                state_r <= S_DONE;
              end
              default: begin
                rsp_r   <= '0;
                state_r <= S_READ;
              end
            endcase
          end
        end
        S_READ: begin
          vtx_r <= {pok_r ? prd : 96'd0, tok_r ? trd[95:32] : 64'd0,
                    nok_r ? nrd : 96'd0};
          scan_r  <= '0;
          state_r <= S_LOAD;
        end
        S_LOAD: begin
          // entry zero read issued this cycle
          state_r <= S_SCAN;
        end
        S_SCAN: begin
          scan_r <= scan_nxt;
          if (hit) begin
            rsp_r.slot_index <= 10'(scan_r);
            state_r <= S_DONE;
          end else if (scan_r >= ucnt_r) begin
            if (uwe) begin
              rsp_r.slot_index <= 10'(ucnt_r);
              rsp_r.is_new     <= 1'b1;
              {rsp_r.pos_x, rsp_r.pos_y, rsp_r.pos_z, rsp_r.tex_u, rsp_r.tex_v,
               rsp_r.nrm_x, rsp_r.nrm_y, rsp_r.nrm_z} <= vtx_r;
              ucnt_r <= ucnt_r + UCW'(1);
            end else begin
              rsp_r.store_full <= 1'b1;
            end
            state_r <= S_DONE;
          end
        end
        S_DONE: begin
          valid_r <= 1'b1;
          state_r <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  // S_DONE result pulses as valid_r next cycle; hold busy through it
  assign busy      = (state_r != S_IDLE) || valid_r;
  assign out_valid = valid_r;
  assign out_rsp   = rsp_r;

  `VDI_ASSERT_IMP(a_cnt_bound, 1'b1, ucnt_r <= UCW'(UNIQUE_DEPTH), "unique count over depth")
  `VDI_ASSERT_NXT(a_one_result, valid_r, !valid_r, "result strobe longer than one cycle")
  `VDI_ASSERT_IMP(a_new_not_full, valid_r, !(rsp_r.is_new && rsp_r.store_full), "new and full")
  `VDI_ASSERT_NXT(a_done_valid, state_r == S_DONE, valid_r, "missing result after done")
endmodule
